// ----- rtl/qap_pkg.sv -----
// Shared types, constants and state encodings for the quaternion attitude PID block.
package qap_pkg;

  localparam int unsigned QAP_INT_BITS = 32;
  localparam int unsigned QAP_QDEPTH   = 2;
  localparam int unsigned QAP_HSUM_W   = 34;
  localparam int unsigned QAP_ERR_W    = 21;
  localparam int unsigned QAP_TRQ_W    = 24;

  // Subtract mask for the sixteen Hamilton terms, term k = row*4 + j,
  // row = w,x,y,z of the error, j = w,x,y,z of the measured quaternion.
  localparam logic [15:0] QAP_HAM_NEG    = 16'hAC60;
  localparam logic [15:0] QAP_PERIOD_RST = 16'd66;

  typedef enum logic [1:0] {
    CFG_X_GAINS = 2'd0,
    CFG_Y_GAINS = 2'd1,
    CFG_Z_GAINS = 2'd2,
    CFG_PERIOD  = 2'd3
  } qap_cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] target_w;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_z;
    logic signed [15:0] meas_w;
    logic signed [15:0] meas_x;
    logic signed [15:0] meas_y;
    logic signed [15:0] meas_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } qap_in_t;

  typedef struct packed {
    logic signed [QAP_TRQ_W-1:0] torque_x;
    logic signed [QAP_TRQ_W-1:0] torque_y;
    logic signed [QAP_TRQ_W-1:0] torque_z;
    logic                        clipped;
  } qap_out_t;

  typedef struct packed {
    logic [15:0]        limit;
    logic signed [15:0] kd;
    logic signed [15:0] ki;
    logic signed [15:0] kp;
  } qap_gains_t;

  typedef struct packed {
    logic signed [QAP_ERR_W-1:0] err_x;
    logic signed [QAP_ERR_W-1:0] err_y;
    logic signed [QAP_ERR_W-1:0] err_z;
    logic signed [15:0]          rate_x;
    logic signed [15:0]          rate_y;
    logic signed [15:0]          rate_z;
  } qap_job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } qap_fstate_e;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } qap_bstate_e;

  typedef enum logic [2:0] {
    ST_PERIOD,
    ST_CLAMP,
    ST_KI,
    ST_KD,
    ST_SUM
  } qap_step_e;

endpackage

// ----- rtl/qap_if.sv -----
// Handshake channels: input items, result items and configuration writes.
interface qap_in_if;
  import qap_pkg::*;
  logic    valid;
  logic    ready;
  qap_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qap_out_if;
  import qap_pkg::*;
  logic     valid;
  logic     ready;
  qap_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qap_cfg_if;
  import qap_pkg::*;
  logic         valid;
  logic         ready;
  qap_cfg_idx_e index;
  logic [63:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/qap_queue.sv -----
// Short queue of attitude-error items between the front and the back.
module qap_queue #(
  parameter int unsigned DEPTH = qap_pkg::QAP_QDEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  qap_pkg::qap_job_t data_i,
  input  logic              pop_i,
  output qap_pkg::qap_job_t data_o,
  output logic              full_o,
  output logic              empty_o
);
  import qap_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  qap_job_t           mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d;
  logic [PTR_W-1:0]   rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/qap_front.sv -----
// Front end: takes an item and forms the attitude error with one shared 16x16 multiplier.
module qap_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  qap_in_if.sink            in_i,
  input  logic              full_i,
  output logic              push_o,
  output qap_pkg::qap_job_t job_o
);
  import qap_pkg::*;

  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(16);

  qap_fstate_e              state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  qap_in_t                  item_q;
  logic signed [31:0]       prod_q;
  logic signed [QAP_HSUM_W-1:0] acc_q [4];

  logic signed [15:0]       mul_a;
  logic signed [15:0]       mul_t;
  logic [1:0]               t_sel;
  logic [3:0]               term;
  logic signed [QAP_HSUM_W-1:0] prod_ext;
  logic signed [QAP_ERR_W-1:0]  err [3];
  logic                     accept;

  assign accept = in_i.valid && in_i.ready;
  assign t_sel  = cnt_q[3:2] ^ cnt_q[1:0];
  // term just multiplied: the counter has moved on by one
  assign term     = cnt_q[3:0] - 4'd1;
  assign prod_ext = QAP_HSUM_W'(prod_q);

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    mul_a = item_q.meas_w;
      2'd1:    mul_a = item_q.meas_x;
      2'd2:    mul_a = item_q.meas_y;
      default: mul_a = item_q.meas_z;
    endcase
    unique case (t_sel)
      2'd0:    mul_t = item_q.target_w;
      2'd1:    mul_t = item_q.target_x;
      2'd2:    mul_t = item_q.target_y;
      default: mul_t = item_q.target_z;
    endcase
  end

  // Take the shortest path: flip the vector part when the scalar part is negative.
  always_comb begin
    logic signed [QAP_HSUM_W-1:0] v;
    logic signed [QAP_HSUM_W-1:0] vr;
    for (int r = 0; r < 3; r++) begin
      v      = acc_q[0][QAP_HSUM_W-1] ? -acc_q[r+1] : acc_q[r+1];
      vr     = v + QAP_HSUM_W'(4096);
      err[r] = vr[QAP_HSUM_W-1:13];
    end
  end

  assign job_o.err_x  = err[0];
  assign job_o.err_y  = err[1];
  assign job_o.err_z  = err[2];
  assign job_o.rate_x = item_q.rate_x;
  assign job_o.rate_y = item_q.rate_y;
  assign job_o.rate_z = item_q.rate_z;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_MUL;
          cnt_d   = '0;
        end
      end
      F_MUL: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready = (state_q == F_IDLE);
    push_o     = (state_q == F_PUSH) && !full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i.data;
      for (int r = 0; r < 4; r++) begin
        acc_q[r] <= '0;
      end
    end
    if (state_q == F_MUL) begin
      prod_q <= mul_a * mul_t;
      if (cnt_q != '0) begin
        if (QAP_HAM_NEG[term]) begin
          acc_q[term[3:2]] <= acc_q[term[3:2]] - prod_ext;
        end else begin
          acc_q[term[3:2]] <= acc_q[term[3:2]] + prod_ext;
        end
      end
    end
  end

endmodule

// ----- rtl/qap_back.sv -----
// Back end: per-axis integrator and PID torque through one shared multiplier.
module qap_back #(
  parameter int unsigned INT_BITS = qap_pkg::QAP_INT_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  qap_pkg::qap_job_t   job_i,
  output logic                pop_o,
  input  qap_pkg::qap_gains_t gains_i [3],
  input  logic [15:0]         period_i,
  qap_out_if.source           out_o
);
  import qap_pkg::*;

  localparam int FRAC   = INT_BITS - 8;
  localparam int ACC_W  = INT_BITS + 1;
  localparam int P_W    = ACC_W + 17;
  localparam int T_W    = 38;
  localparam int SH_R   = (FRAC <= 30) ? 30 - FRAC : 0;
  localparam int SH_L   = (FRAC > 30) ? FRAC - 30 : 0;
  localparam int KI_SH  = FRAC - 14;
  localparam int LIM_SH = FRAC - 12;
  localparam logic signed [P_W-1:0] RND   = P_W'((2 ** SH_R) / 2);
  localparam logic signed [T_W-1:0] T_MAX = T_W'(8388607);
  localparam logic signed [T_W-1:0] T_MIN = -(T_W'(8388608));

  qap_bstate_e             state_q, state_d;
  qap_step_e               step_q, step_d;
  logic [1:0]              axis_q, axis_d;
  qap_job_t                job_q;
  logic signed [INT_BITS-1:0] integ_q [3];
  logic signed [ACC_W-1:0] acc_q;
  logic signed [P_W-1:0]   p_q;
  logic signed [T_W-1:0]   t_q;
  logic signed [QAP_TRQ_W-1:0] tq_q [2];
  logic                    clip_q;
  qap_out_t                out_q;
  logic                    out_valid_q;

  logic                    last, fin_ok, finish, stall;
  qap_gains_t              g;
  logic signed [QAP_ERR_W-1:0] err_sel;
  logic signed [15:0]      rate_sel;
  logic signed [16:0]      mul_a;
  logic signed [ACC_W-1:0] mul_b;
  logic signed [P_W-1:0]   mul_p;
  logic signed [P_W-1:0]   inc_p;
  logic signed [ACC_W-1:0] sum, lim_v, clamp;
  logic signed [T_W-1:0]   kd_term, t_fin, t_rnd;
  logic signed [QAP_TRQ_W-1:0] sat_now;
  logic                    clip_now;

  assign g = gains_i[axis_q];

  always_comb begin
    unique case (axis_q)
      2'd0: begin
        err_sel  = job_q.err_x;
        rate_sel = job_q.rate_x;
      end
      2'd1: begin
        err_sel  = job_q.err_y;
        rate_sel = job_q.rate_y;
      end
      default: begin
        err_sel  = job_q.err_z;
        rate_sel = job_q.rate_z;
      end
    endcase
  end

  always_comb begin
    unique case (step_q)
      ST_PERIOD: begin
        mul_a = $signed({1'b0, period_i});
        mul_b = ACC_W'(err_sel);
      end
      ST_CLAMP: begin
        mul_a = 17'(g.kp);
        mul_b = ACC_W'(err_sel);
      end
      ST_KI: begin
        mul_a = 17'(g.ki);
        mul_b = acc_q;
      end
      default: begin
        mul_a = 17'(g.kd);
        mul_b = ACC_W'(rate_sel);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Integrator step: round the increment to the integrator's fraction, then clamp.
  always_comb begin
    inc_p = ((p_q + RND) >>> SH_R) <<< SH_L;
    sum   = ACC_W'(integ_q[axis_q]) + ACC_W'(inc_p);
    lim_v = $signed(ACC_W'(g.limit) << LIM_SH);
    priority if (sum > lim_v) begin
      clamp = lim_v;
    end else if (sum < -lim_v) begin
      clamp = -lim_v;
    end else begin
      clamp = sum;
    end
  end

  // Torque: subtract the damping term, round to Q.15 and saturate.
  always_comb begin
    kd_term  = T_W'(p_q) <<< 4;
    t_fin    = t_q - kd_term;
    t_rnd    = (t_fin + T_W'(64)) >>> 7;
    clip_now = 1'b0;
    priority if (t_rnd > T_MAX) begin
      sat_now  = QAP_TRQ_W'(T_MAX);
      clip_now = 1'b1;
    end else if (t_rnd < T_MIN) begin
      sat_now  = QAP_TRQ_W'(T_MIN);
      clip_now = 1'b1;
    end else begin
      sat_now = QAP_TRQ_W'(t_rnd);
    end
  end

  // outputs
  always_comb begin
    pop_o       = (state_q == B_IDLE) && !empty_i;
    fin_ok      = !out_valid_q || out_o.ready;
    last        = (state_q == B_RUN) && (step_q == ST_SUM) && (axis_q == 2'd2);
    finish      = last && fin_ok;
    stall       = last && !fin_ok;
    out_o.valid = out_valid_q;
    out_o.data  = out_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    axis_d  = axis_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          state_d = B_RUN;
          step_d  = ST_PERIOD;
          axis_d  = 2'd0;
        end
      end
      B_RUN: begin
        if (finish) begin
          state_d = B_IDLE;
        end else if (!stall) begin
          unique case (step_q)
            ST_PERIOD: step_d = ST_CLAMP;
            ST_CLAMP:  step_d = ST_KI;
            ST_KI:     step_d = ST_KD;
            ST_KD:     step_d = ST_SUM;
            default: begin
              step_d = ST_PERIOD;
              axis_d = axis_q + 2'd1;
            end
          endcase
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= ST_PERIOD;
      axis_q      <= 2'd0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        integ_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == B_RUN && step_q == ST_CLAMP) begin
        integ_q[axis_q] <= clamp[INT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q  <= job_i;
      clip_q <= 1'b0;
    end
    if (state_q == B_RUN) begin
      unique case (step_q)
        ST_PERIOD: p_q <= mul_p;
        ST_CLAMP: begin
          acc_q <= clamp;
          p_q   <= mul_p;
        end
        ST_KI: begin
          t_q <= T_W'(p_q);
          p_q <= mul_p;
        end
        ST_KD: begin
          t_q <= t_q + T_W'(p_q >>> KI_SH);
          p_q <= mul_p;
        end
        default: begin
          if (!last) begin
            tq_q[axis_q[0]] <= sat_now;
            clip_q          <= clip_q | clip_now;
          end else if (finish) begin
            out_q.torque_x <= tq_q[0];
            out_q.torque_y <= tq_q[1];
            out_q.torque_z <= sat_now;
            out_q.clipped  <= clip_q | clip_now;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/quaternion_attitude_pid.sv -----
// The front takes no new item until it has pushed the last one into the queue: its
// single 16x16 multiplier works through the sixteen Hamilton product terms in turn.
// The back handles one queued item at a time, axis by axis.
// Reset clears the integrators and gains, sets the sample period to 66 and
// empties the queue; the block is ready for items straight out of reset.
module quaternion_attitude_pid #(
  parameter int unsigned INTEGRATOR_BITS = qap_pkg::QAP_INT_BITS,
  parameter int unsigned QUEUE_DEPTH     = qap_pkg::QAP_QDEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qap_in_if.sink    in_i,
  qap_cfg_if.sink   cfg_i,
  qap_out_if.source out_o
);
  import qap_pkg::*;

  qap_gains_t  gains_q [3];
  logic [15:0] period_q;

  logic        push, pop, full, empty;
  qap_job_t    job_push, job_pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        gains_q[k] <= '0;
      end
      period_q <= QAP_PERIOD_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_X_GAINS: gains_q[0] <= qap_gains_t'(cfg_i.data);
        CFG_Y_GAINS: gains_q[1] <= qap_gains_t'(cfg_i.data);
        CFG_Z_GAINS: gains_q[2] <= qap_gains_t'(cfg_i.data);
        CFG_PERIOD:  period_q   <= cfg_i.data[15:0];
        default:     period_q   <= period_q;
      endcase
    end
  end

  qap_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_push)
  );

  qap_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_push),
    .pop_i   (pop),
    .data_o  (job_pop),
    .full_o  (full),
    .empty_o (empty)
  );

  qap_back #(
    .INT_BITS (INTEGRATOR_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .job_i    (job_pop),
    .pop_o    (pop),
    .gains_i  (gains_q),
    .period_i (period_q),
    .out_o    (out_o)
  );

endmodule

// ----- rtl/qap_checker.sv -----
// Port-level checks for the attitude PID top level, bound to it.
module qap_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input qap_pkg::qap_out_t out_data_i
);
  import qap_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("front took a second item while still busy");

  a_quiet_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result shown straight after reset");

endmodule

bind quaternion_attitude_pid qap_checker u_qap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
